>>> rtl/core/tasp_pkg.sv
package tasp_pkg;

    // Command codes of the input beat.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_MOVE_X = 2'd1;
    localparam logic [1:0] CMD_MOVE_Y = 2'd2;
    localparam logic [1:0] CMD_HOME   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_UNIT_CYCLES  = 2'd0;
    localparam logic [1:0] CFG_BEEP_DIVIDER = 2'd1;
    localparam logic [1:0] CFG_PHASE_TICKS  = 2'd2;
    localparam logic [1:0] CFG_BEEP_TICKS   = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    // Register reset values.
    localparam logic [9:0]  UNIT_CYCLES_RST  = 10'd511;
    localparam logic [4:0]  BEEP_DIVIDER_RST = 5'd1;
    localparam logic [19:0] PHASE_TICKS_RST  = 20'd1000;
    localparam logic [15:0] BEEP_TICKS_RST   = 16'd1000;

    // Position limits.
    localparam logic signed [3:0] POS_MAX = 4'sd5;
    localparam logic signed [3:0] POS_MIN = -4'sd5;

    // Buzzer window bounds of a move, compared against (cycle + 1) * divider.
    localparam logic [15:0] MOVE_WIN0_END   = 16'd50;
    localparam logic [15:0] MOVE_WIN1_START = 16'd130;
    localparam logic [15:0] MOVE_WIN1_END   = 16'd180;
    localparam logic [15:0] MOVE_WIN2_START = 16'd260;
    localparam logic [15:0] MOVE_WIN2_END   = 16'd310;
    localparam logic [15:0] MOVE_WIN3_START = 16'd390;
    localparam logic [15:0] MOVE_WIN3_END   = 16'd440;

    // Homing beep pattern.
    localparam logic [10:0] BEEP_WIN0_END   = 11'd200;
    localparam logic [10:0] BEEP_WIN1_START = 11'd400;
    localparam logic [10:0] BEEP_WIN1_END   = 11'd600;
    localparam logic [10:0] BEEP_WIN2_START = 11'd800;
    localparam logic [10:0] BEEP_WIN2_END   = 11'd1000;
    localparam logic [10:0] BEEP_WIN3_START = 11'd1200;
    localparam logic [10:0] BEEP_WIN3_END   = 11'd1400;
    localparam logic [10:0] BEEP_LAST_ITER  = 11'd1400;

    typedef struct packed {
        logic [1:0]        command;
        logic signed [3:0] target;
    } t_item;

    typedef struct packed {
        logic [3:0]        coils_x;
        logic [3:0]        coils_y;
        logic              buzzer_on;
        logic signed [3:0] position_x;
        logic signed [3:0] position_y;
        logic              busy_res;
        logic              rejected;
    } t_result;

    typedef struct packed {
        logic                   en;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_write;

    // Clockwise half-step coil pattern, bit3 = IN1 .. bit0 = IN4.
    function automatic logic [3:0] seq_cw(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0: pat = 4'h8;
            3'd1: pat = 4'hC;
            3'd2: pat = 4'h4;
            3'd3: pat = 4'h6;
            3'd4: pat = 4'h2;
            3'd5: pat = 4'h3;
            3'd6: pat = 4'h1;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

    // Counter-clockwise half-step coil pattern.
    function automatic logic [3:0] seq_ccw(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0: pat = 4'h1;
            3'd1: pat = 4'h3;
            3'd2: pat = 4'h2;
            3'd3: pat = 4'h6;
            3'd4: pat = 4'h4;
            3'd5: pat = 4'hC;
            3'd6: pat = 4'h8;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

>>> rtl/core/tasp_in_stage.sv
module tasp_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_command,
    input  logic signed [3:0] i_target,
    input  logic            i_adv,
    output logic            o_valid,
    output tasp_pkg::t_item o_item
);
    import tasp_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;

    // The stage refills in the same cycle that its beat moves on.
    assign o_stall  = r_valid && !i_adv;
    assign w_accept = i_valid && !o_stall;
    assign n_valid  = w_accept || (r_valid && !i_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.command <= i_command;
            r_item.target  <= i_target;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/tasp_engine.sv
module tasp_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  tasp_pkg::t_item      i_item,
    input  tasp_pkg::t_cfg_write i_cfg,
    output tasp_pkg::t_result    o_result
);
    import tasp_pkg::*;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_MOVE_X = 3'd1;
    localparam logic [2:0] MODE_MOVE_Y = 3'd2;
    localparam logic [2:0] MODE_BEEP   = 3'd3;
    localparam logic [2:0] MODE_HOME_X = 3'd4;
    localparam logic [2:0] MODE_HOME_Y = 3'd5;

    logic [9:0]  r_unit_cycles;
    logic [4:0]  r_beep_divider;
    logic [19:0] r_phase_ticks;
    logic [15:0] r_beep_ticks;

    logic signed [3:0] r_pos_x, r_pos_y, r_goal_x, r_goal_y;
    logic signed [3:0] n_pos_x, n_pos_y, n_goal_x, n_goal_y;
    logic [2:0]  r_mode, n_mode;
    logic [2:0]  r_phase, n_phase;
    logic [9:0]  r_cycle, n_cycle;
    logic [19:0] r_tick, n_tick;
    logic [10:0] r_beep_iter, n_beep_iter;

    // Values after the command of this beat has been applied.
    logic signed [3:0] s_goal_x, s_goal_y;
    logic [2:0]  s_mode;
    logic [2:0]  s_phase;
    logic [9:0]  s_cycle;
    logic [19:0] s_tick;
    logic [10:0] s_beep_iter;
    logic        s_rejected;

    logic signed [3:0] w_target;
    logic [4:0]  w_div;
    logic [19:0] w_phase_lim;
    logic [15:0] w_beep_lim;
    logic [20:0] w_tick_inc;
    logic        w_phase_end;
    logic        w_beep_end;
    logic [10:0] w_cycle_inc;
    logic [15:0] w_prod;
    logic        w_unit_end;
    logic        w_move_buz;
    logic        w_beep_buz;
    logic        w_axis_x;
    logic signed [3:0] w_pos;
    logic signed [3:0] w_goal;
    logic signed [3:0] w_pos_next;
    logic        w_up;
    logic [3:0]  w_pattern;
    t_result     w_result;

    // Ends every motion whose axis already stands at its goal.
    function automatic logic [2:0] settle(
        input logic [2:0]        m,
        input logic signed [3:0] px,
        input logic signed [3:0] py,
        input logic signed [3:0] gx,
        input logic signed [3:0] gy
    );
        logic [2:0] res;
        unique case (m)
            MODE_MOVE_X: res = (px == gx) ? MODE_IDLE : MODE_MOVE_X;
            MODE_MOVE_Y: res = (py == gy) ? MODE_IDLE : MODE_MOVE_Y;
            MODE_HOME_X: begin
                if (px != gx) begin
                    res = MODE_HOME_X;
                end else begin
                    res = (py == gy) ? MODE_IDLE : MODE_HOME_Y;
                end
            end
            MODE_HOME_Y: res = (py == gy) ? MODE_IDLE : MODE_HOME_Y;
            default:     res = m;
        endcase
        return res;
    endfunction

    always_comb begin
        if (i_item.target > POS_MAX) begin
            w_target = POS_MAX;
        end else if (i_item.target < POS_MIN) begin
            w_target = POS_MIN;
        end else begin
            w_target = i_item.target;
        end
    end

    assign w_div       = (r_beep_divider == 5'd0) ? 5'd1 : r_beep_divider;
    assign w_phase_lim = (r_phase_ticks == 20'd0) ? 20'd1 : r_phase_ticks;
    assign w_beep_lim  = (r_beep_ticks == 16'd0) ? 16'd1 : r_beep_ticks;

    // Command decode: a command starts only from idle.
    always_comb begin
        s_goal_x    = r_goal_x;
        s_goal_y    = r_goal_y;
        s_mode      = r_mode;
        s_phase     = r_phase;
        s_cycle     = r_cycle;
        s_tick      = r_tick;
        s_beep_iter = r_beep_iter;
        s_rejected  = 1'b0;
        if (r_mode != MODE_IDLE) begin
            s_rejected = (i_item.command != CMD_TICK);
        end else if (i_item.command != CMD_TICK) begin
            s_phase     = 3'd0;
            s_cycle     = 10'd0;
            s_tick      = 20'd0;
            s_beep_iter = 11'd0;
            unique case (i_item.command)
                CMD_MOVE_X: begin
                    s_goal_x = w_target;
                    s_mode   = settle(MODE_MOVE_X, r_pos_x, r_pos_y, w_target, r_goal_y);
                end
                CMD_MOVE_Y: begin
                    s_goal_y = w_target;
                    s_mode   = settle(MODE_MOVE_Y, r_pos_x, r_pos_y, r_goal_x, w_target);
                end
                default: begin
                    s_goal_x = 4'sd0;
                    s_goal_y = 4'sd0;
                    s_mode   = MODE_BEEP;
                end
            endcase
        end
    end

    // cycle >= unit/d  <=>  (cycle + 1) * d > unit, and the buzzer windows
    // follow the same rewrite, so one small product replaces all divisions.
    assign w_cycle_inc = {1'b0, s_cycle} + 11'd1;
    assign w_prod      = {5'd0, w_cycle_inc} * {11'd0, w_div};
    assign w_unit_end  = w_prod > {6'd0, r_unit_cycles};
    assign w_move_buz  = (w_prod <= MOVE_WIN0_END) ||
                         (w_prod > MOVE_WIN1_START && w_prod <= MOVE_WIN1_END) ||
                         (w_prod > MOVE_WIN2_START && w_prod <= MOVE_WIN2_END) ||
                         (w_prod > MOVE_WIN3_START && w_prod <= MOVE_WIN3_END);
    assign w_beep_buz  = (s_beep_iter < BEEP_WIN0_END) ||
                         (s_beep_iter >= BEEP_WIN1_START && s_beep_iter < BEEP_WIN1_END) ||
                         (s_beep_iter >= BEEP_WIN2_START && s_beep_iter < BEEP_WIN2_END) ||
                         (s_beep_iter >= BEEP_WIN3_START && s_beep_iter < BEEP_WIN3_END);

    assign w_tick_inc  = {1'b0, s_tick} + 21'd1;
    assign w_phase_end = w_tick_inc >= {1'b0, w_phase_lim};
    assign w_beep_end  = w_tick_inc >= {5'd0, w_beep_lim};

    assign w_axis_x   = (s_mode == MODE_MOVE_X) || (s_mode == MODE_HOME_X);
    assign w_pos      = w_axis_x ? r_pos_x : r_pos_y;
    assign w_goal     = w_axis_x ? s_goal_x : s_goal_y;
    assign w_up       = w_pos < w_goal;
    assign w_pos_next = w_up ? (w_pos + 4'sd1) : (w_pos - 4'sd1);
    assign w_pattern  = w_up ? seq_cw(s_phase) : seq_ccw(s_phase);

    // One tick of the running operation.
    always_comb begin
        n_goal_x    = s_goal_x;
        n_goal_y    = s_goal_y;
        n_mode      = s_mode;
        n_phase     = s_phase;
        n_cycle     = s_cycle;
        n_tick      = s_tick;
        n_beep_iter = s_beep_iter;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        w_result    = '0;
        w_result.rejected = s_rejected;
        unique case (s_mode)
            MODE_BEEP: begin
                w_result.busy_res  = 1'b1;
                w_result.buzzer_on = w_beep_buz;
                if (w_beep_end) begin
                    n_tick = 20'd0;
                    if (s_beep_iter >= BEEP_LAST_ITER) begin
                        n_beep_iter = 11'd0;
                        n_phase     = 3'd0;
                        n_cycle     = 10'd0;
                        n_mode      = settle(MODE_HOME_X, r_pos_x, r_pos_y,
                                             s_goal_x, s_goal_y);
                    end else begin
                        n_beep_iter = s_beep_iter + 11'd1;
                    end
                end else begin
                    n_tick = w_tick_inc[19:0];
                end
            end
            MODE_MOVE_X, MODE_MOVE_Y, MODE_HOME_X, MODE_HOME_Y: begin
                w_result.busy_res  = 1'b1;
                w_result.buzzer_on = w_move_buz;
                if (w_axis_x) begin
                    w_result.coils_x = w_pattern;
                end else begin
                    w_result.coils_y = w_pattern;
                end
                if (w_phase_end) begin
                    n_tick = 20'd0;
                    if (s_phase == 3'd7) begin
                        n_phase = 3'd0;
                        if (w_unit_end) begin
                            n_cycle = 10'd0;
                            if (w_axis_x) begin
                                n_pos_x = w_pos_next;
                            end else begin
                                n_pos_y = w_pos_next;
                            end
                            n_mode = settle(s_mode, n_pos_x, n_pos_y, s_goal_x, s_goal_y);
                        end else begin
                            n_cycle = s_cycle + 10'd1;
                        end
                    end else begin
                        n_phase = s_phase + 3'd1;
                    end
                end else begin
                    n_tick = w_tick_inc[19:0];
                end
            end
            default: begin
                n_mode = s_mode;
            end
        endcase
        w_result.position_x = n_pos_x;
        w_result.position_y = n_pos_y;
    end

    assign o_result = w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_cycles  <= UNIT_CYCLES_RST;
            r_beep_divider <= BEEP_DIVIDER_RST;
            r_phase_ticks  <= PHASE_TICKS_RST;
            r_beep_ticks   <= BEEP_TICKS_RST;
        end else if (i_cfg.en) begin
            unique case (i_cfg.index)
                CFG_UNIT_CYCLES:  r_unit_cycles  <= i_cfg.data[9:0];
                CFG_BEEP_DIVIDER: r_beep_divider <= i_cfg.data[4:0];
                CFG_PHASE_TICKS:  r_phase_ticks  <= i_cfg.data[19:0];
                CFG_BEEP_TICKS:   r_beep_ticks   <= i_cfg.data[15:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= 4'sd0;
            r_pos_y     <= 4'sd0;
            r_goal_x    <= 4'sd0;
            r_goal_y    <= 4'sd0;
            r_mode      <= MODE_IDLE;
            r_phase     <= 3'd0;
            r_cycle     <= 10'd0;
            r_tick      <= 20'd0;
            r_beep_iter <= 11'd0;
        end else if (i_adv) begin
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_goal_x    <= n_goal_x;
            r_goal_y    <= n_goal_y;
            r_mode      <= n_mode;
            r_phase     <= n_phase;
            r_cycle     <= n_cycle;
            r_tick      <= n_tick;
            r_beep_iter <= n_beep_iter;
        end
    end

endmodule

>>> rtl/core/tasp_out_stage.sv
module tasp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tasp_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_adv,
    output logic              o_valid,
    output tasp_pkg::t_result o_result
);
    import tasp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // The result register takes a new beat when empty or when its beat leaves.
    assign o_adv   = i_in_valid && (!r_valid || !i_stall);
    assign n_valid = o_adv || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> rtl/core/two_axis_stepper_half_step_positioner.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+--------------------------------------
// input    | in        | i_in_valid / o_in_stall   | i_command, i_target
// result   | out       | o_out_valid / i_out_stall | coils, buzzer, positions, busy, rejected
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One beat is accepted every cycle unless o_in_stall is high; it reaches the result register
// via the input register. The rate is set by the single step of the positioner, whose
// longest path is one 11 by 5 bit product followed by a compare and the state selection.
// Reset is synchronous and active low; it clears all positions, the operation state
// and the handshake registers, and loads the register reset values.
// A stall on the result side holds the result register and then the input register,
// and the input side stalls only while both are full.
module two_axis_stepper_half_step_positioner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_command,
    input  logic signed [3:0]               i_target,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [3:0]                      o_coils_x,
    output logic [3:0]                      o_coils_y,
    output logic                            o_buzzer_on,
    output logic signed [3:0]               o_position_x,
    output logic signed [3:0]               o_position_y,
    output logic                            o_busy_res,
    output logic                            o_rejected,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tasp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tasp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tasp_pkg::*;

    logic       w_item_valid;
    t_item      w_item;
    logic       w_adv;
    t_cfg_write w_cfg;
    t_result    w_step_result;
    t_result    w_out_result;

    // Register writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;
    assign w_cfg.en    = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    // Input register: holds one command beat ahead of the step logic.
    tasp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_command (i_command),
        .i_target  (i_target),
        .i_adv     (w_adv),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    // Positioner state and the step that one beat performs; the state only moves
    // when the beat really advances into the result register.
    tasp_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (w_item),
        .i_cfg    (w_cfg),
        .o_result (w_step_result)
    );

    // Result register: parts the result side from the input side.
    tasp_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (w_item_valid),
        .i_result   (w_step_result),
        .i_stall    (i_out_stall),
        .o_adv      (w_adv),
        .o_valid    (o_out_valid),
        .o_result   (w_out_result)
    );

    assign o_coils_x    = w_out_result.coils_x;
    assign o_coils_y    = w_out_result.coils_y;
    assign o_buzzer_on  = w_out_result.buzzer_on;
    assign o_position_x = w_out_result.position_x;
    assign o_position_y = w_out_result.position_y;
    assign o_busy_res   = w_out_result.busy_res;
    assign o_rejected   = w_out_result.rejected;

endmodule

>>> rtl/core/tasp_checker.sv
module tasp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [3:0]        o_coils_x,
    input logic [3:0]        o_coils_y,
    input logic              o_buzzer_on,
    input logic signed [3:0] o_position_x,
    input logic signed [3:0] o_position_y,
    input logic              o_busy_res,
    input logic              o_rejected
);
    import tasp_pkg::*;

    // Only one axis is driven at a time, and only while an operation runs.
    a_one_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_coils_x == 4'h0 || o_coils_y == 4'h0))
        else $error("both axes driven in one beat");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_coils_x != 4'h0 || o_coils_y != 4'h0 || o_buzzer_on ||
         o_rejected)) |-> o_busy_res)
        else $error("coil, buzzer or reject without busy");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_position_x >= POS_MIN && o_position_x <= POS_MAX &&
                         o_position_y >= POS_MIN && o_position_y <= POS_MAX))
        else $error("position out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid &&
        $stable({o_coils_x, o_coils_y, o_buzzer_on, o_position_x, o_position_y,
                 o_busy_res, o_rejected})))
        else $error("stalled result beat changed");

endmodule

bind two_axis_stepper_half_step_positioner tasp_checker u_tasp_checker (.*);
